>>> design/lpc_pkg.sv
// Shared types, codes and helpers for the line printer channel controller.
package lpc_pkg;

   // Item kinds carried in the op field.
   localparam logic [2:0] OP_SI_CMD     = 3'd0;
   localparam logic [2:0] OP_NSI_CMD    = 3'd1;
   localparam logic [2:0] OP_NSI_STATUS = 3'd2;
   localparam logic [2:0] OP_TICK       = 3'd3;
   localparam logic [2:0] OP_CHAR       = 3'd4;

   // Standard interface command codes.
   localparam logic [5:0] CMD_WRITE     = 6'o32;
   localparam logic [5:0] CMD_AUTOWRITE = 6'o02;
   localparam logic [5:0] CMD_SEND_Q    = 6'o20;
   localparam logic [5:0] CMD_SEND_P    = 6'o24;
   localparam logic [5:0] CMD_DISC      = 6'o36;

   // Responses and response bits.
   localparam logic [5:0] RESP_ACCEPT   = 6'd5;
   localparam logic [5:0] RESP_BUSY     = 6'd3;
   localparam logic [5:0] RESP_NOT_RDY  = 6'o40;
   localparam logic [5:0] RESP_IDLE     = 6'o30;

   // Bit positions in the status word.
   localparam int unsigned ST_END  = 0;
   localparam int unsigned ST_OPAT = 1;
   localparam int unsigned ST_ERR  = 2;
   localparam int unsigned ST_BUSY = 5;
   localparam int unsigned ST_DISC = 6;

   // NSI command bits.
   localparam int unsigned NSI_STOP  = 1;
   localparam int unsigned NSI_START = 0;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SI_INTERFACE = 2'd0;
   localparam logic [1:0] CSR_WIDTH_SELECT = 2'd1;
   localparam logic [1:0] CSR_ATTACHED     = 2'd2;

   // Line width codes and column counts.
   localparam logic [1:0] WSEL_96  = 2'd0;
   localparam logic [1:0] WSEL_120 = 2'd1;
   localparam logic [1:0] WSEL_160 = 2'd2;
   localparam logic [7:0] COLS_96  = 8'd96;
   localparam logic [7:0] COLS_120 = 8'd120;
   localparam logic [7:0] COLS_160 = 8'd160;

   typedef struct packed {
      logic       si_interface;
      logic [1:0] width_select;
      logic       attached;
   } cfg_type;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] cmd_code;
      logic [5:0] char_code;
      logic       end_of_record;
   } req_item_type;

   typedef struct packed {
      logic [5:0] resp_word;
      logic       print_valid;
      logic [5:0] print_code;
      logic       line_end;
      logic       done_level;
      logic       reschedule;
      logic       want_chars;
      logic [5:0] qualifier;
   } rsp_item_type;

   // Column count of a line for a width code; the unused code gives 96.
   function automatic logic [7:0] line_width(input logic [1:0] sel);
      logic [7:0] cols;
      case (sel)
         WSEL_120: cols = COLS_120;
         WSEL_160: cols = COLS_160;
         default:  cols = COLS_96;
      endcase
      return cols;
   endfunction

endpackage

>>> design/lpc_ifc.sv
// Channel interfaces for requests, results and configuration writes.
interface lpc_req_if import lpc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [5:0] cmd_code;
   logic [5:0] char_code;
   logic       end_of_record;

   modport source (output valid, op, cmd_code, char_code, end_of_record, input ready);
   modport sink   (input valid, op, cmd_code, char_code, end_of_record, output ready);
endinterface

interface lpc_rsp_if import lpc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [5:0] resp_word;
   logic       print_valid;
   logic [5:0] print_code;
   logic       line_end;
   logic       done_level;
   logic       reschedule;
   logic       want_chars;
   logic [5:0] qualifier;

   modport source (output valid, resp_word, print_valid, print_code, line_end, done_level,
                   reschedule, want_chars, qualifier, input ready);
   modport sink   (input valid, resp_word, print_valid, print_code, line_end, done_level,
                   reschedule, want_chars, qualifier, output ready);
endinterface

interface lpc_csr_if import lpc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/lpc_csr_regs.sv
// Configuration registers: interface style, line width and attached flag.
module lpc_csr_regs import lpc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lpc_csr_if.sink  csr,
   output cfg_type  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an index beyond the list changes nothing.
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_SI_INTERFACE: cfg_in.si_interface = csr.data[0];
            CSR_WIDTH_SELECT: cfg_in.width_select = csr.data;
            CSR_ATTACHED:     cfg_in.attached     = csr.data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{si_interface: 1'b1, width_select: WSEL_120, attached: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/lpc_core.sv
// Controller state and the single-pass update for one request.
module lpc_core import lpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  cfg_type      cfg,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [6:0] status_ff,  status_in;
   logic       qual_ff,    qual_in;
   logic       auto_ff,    auto_in;
   logic [5:0] qvalue_ff,  qvalue_in;
   logic       printing_ff, printing_in;
   logic [7:0] column_ff,  column_in;
   logic       done_ff,    done_in;

   // Next state and result for the request in the input register.
   always_comb begin
      logic [5:0] resp;
      logic       pvalid;
      logic [5:0] pcode;
      logic       lend;
      logic       resched;

      status_in   = status_ff;
      qual_in     = qual_ff;
      auto_in     = auto_ff;
      qvalue_in   = qvalue_ff;
      printing_in = printing_ff;
      column_in   = column_ff;
      done_in     = done_ff;
      resp        = '0;
      pvalid      = 1'b0;
      pcode       = '0;
      lend        = 1'b0;
      resched     = 1'b0;

      case (item.op)
         OP_SI_CMD: begin
            if (cfg.si_interface) begin
               if (qual_ff) begin
                  // The word after a write is the qualifier, whatever it holds.
                  qvalue_in = item.cmd_code;
                  qual_in   = 1'b0;
                  resp      = RESP_ACCEPT;
               end else begin
                  case (item.cmd_code)
                     CMD_WRITE, CMD_AUTOWRITE: begin
                        if (status_ff[ST_BUSY]) begin
                           resp = RESP_BUSY;
                        end else begin
                           auto_in     = (item.cmd_code == CMD_AUTOWRITE);
                           qual_in     = (item.cmd_code == CMD_WRITE);
                           qvalue_in   = '0;
                           printing_in = 1'b0;
                           column_in   = '0;
                           status_in   = '0;
                           status_in[ST_BUSY] = 1'b1;
                           done_in     = 1'b0;
                           resched     = 1'b1;
                           resp        = RESP_ACCEPT;
                        end
                     end
                     CMD_SEND_Q: begin
                        if (!cfg.attached || (!status_ff[ST_OPAT] && !status_ff[ST_ERR])) begin
                           resp = RESP_NOT_RDY;
                        end
                        resp[0] = status_ff[ST_END];
                        status_in[ST_END] = 1'b0;
                        if (!status_ff[ST_BUSY]) begin
                           resp = resp | RESP_IDLE;
                        end
                     end
                     CMD_SEND_P: begin
                        if (cfg.attached) begin
                           resp = {3'b000, status_ff[ST_ERR], 2'b01};
                        end
                        status_in = '0;
                        done_in   = 1'b0;
                     end
                     CMD_DISC: begin
                        status_in[ST_DISC] = 1'b1;
                        resp = RESP_ACCEPT;
                     end
                     default: resp = '0;
                  endcase
               end
            end
         end
         OP_NSI_CMD: begin
            if (!cfg.si_interface) begin
               if (item.cmd_code[NSI_STOP]) begin
                  if (status_ff[ST_BUSY]) begin
                     status_in[ST_DISC] = 1'b1;
                  end
               end else if (item.cmd_code[NSI_START]) begin
                  if (status_ff[ST_BUSY] || !cfg.attached) begin
                     status_in[ST_OPAT] = 1'b1;
                     done_in = 1'b1;
                  end else begin
                     auto_in   = 1'b1;
                     status_in = '0;
                     status_in[ST_BUSY] = 1'b1;
                     done_in   = 1'b0;
                     resched   = 1'b1;
                  end
               end
            end
         end
         OP_NSI_STATUS: begin
            if (!cfg.si_interface) begin
               // The read clears everything but busy and disconnect.
               resp      = status_ff[5:0];
               status_in = '0;
               status_in[ST_BUSY] = status_ff[ST_BUSY];
               status_in[ST_DISC] = status_ff[ST_DISC];
               done_in   = 1'b0;
            end
         end
         OP_TICK: begin
            if (status_ff[ST_DISC]) begin
               status_in[ST_BUSY] = 1'b0;
               status_in[ST_DISC] = 1'b0;
               status_in[ST_END]  = 1'b1;
               done_in     = 1'b1;
               printing_in = 1'b0;
            end else if (status_ff[ST_BUSY]) begin
               if (!cfg.attached) begin
                  status_in = '0;
                  status_in[ST_ERR] = 1'b1;
                  status_in[ST_END] = 1'b1;
                  done_in     = 1'b1;
                  printing_in = 1'b0;
               end else if (qual_ff) begin
                  resched = 1'b1;
               end else if (!printing_ff) begin
                  printing_in = 1'b1;
                  column_in   = '0;
               end
            end
         end
         OP_CHAR: begin
            if (printing_ff) begin
               if (auto_ff) begin
                  // First character of an autowrite becomes the qualifier.
                  qvalue_in = item.char_code;
                  auto_in   = 1'b0;
               end else begin
                  pvalid    = 1'b1;
                  pcode     = item.char_code;
                  column_in = column_ff + 8'd1;
               end
               if (item.end_of_record || column_in >= line_width(cfg.width_select)) begin
                  printing_in = 1'b0;
                  lend        = 1'b1;
                  if (item.end_of_record) begin
                     status_in[ST_END]  = 1'b1;
                     status_in[ST_BUSY] = 1'b0;
                     status_in[ST_DISC] = 1'b0;
                     done_in = 1'b1;
                  end
               end
            end
         end
         default: resp = '0;
      endcase

      result.resp_word   = resp;
      result.print_valid = pvalid;
      result.print_code  = pcode;
      result.line_end    = lend;
      result.done_level  = done_in;
      result.reschedule  = resched;
      result.want_chars  = printing_in;
      result.qualifier   = qvalue_in;
   end

   // State moves on only when the request is handed to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= '0;
         qual_ff     <= 1'b0;
         auto_ff     <= 1'b0;
         qvalue_ff   <= '0;
         printing_ff <= 1'b0;
         column_ff   <= '0;
         done_ff     <= 1'b0;
      end else if (enable) begin
         status_ff   <= status_in;
         qual_ff     <= qual_in;
         auto_ff     <= auto_in;
         qvalue_ff   <= qvalue_in;
         printing_ff <= printing_in;
         column_ff   <= column_in;
         done_ff     <= done_in;
      end
   end

endmodule

>>> design/line_printer_channel_controller.sv
// Top level of the line printer channel controller.
//
// Requests arrive on req: SI and NSI commands, NSI status reads, service
// ticks and channel characters, selected by op. Every request yields exactly
// one result on rsp, carrying the command response, the character to place
// in the print line, the line end mark, the done level, the request for
// another tick, the line fill flag and the qualifier.
// The csr channel writes the interface style, the line width code and the
// attached flag; it is always ready and should be written only while idle.
// A request is taken into an input register, evaluated combinationally
// against the controller state and placed in the result register, from
// which its result is offered. One request is taken every cycle while
// rsp.ready stays high; each request sees the state update of the last.
// While the receiver holds rsp.ready low, the result register keeps its
// result, the input register keeps one more request, and req.ready falls.
// Synchronous reset empties both registers, clears the controller state and
// restores the configuration to standard interface, 120 columns, unattached.
module line_printer_channel_controller import lpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lpc_req_if.sink    req,
   lpc_rsp_if.source  rsp,
   lpc_csr_if.sink    csr
);

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         advance;

   lpc_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // The request in the input register moves on when the result slot frees.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = (req.valid && req.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   lpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (core_result)
   );

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff <= '{op: req.op, cmd_code: req.cmd_code, char_code: req.char_code,
                         end_of_record: req.end_of_record};
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.resp_word   = out_item_ff.resp_word;
   assign rsp.print_valid = out_item_ff.print_valid;
   assign rsp.print_code  = out_item_ff.print_code;
   assign rsp.line_end    = out_item_ff.line_end;
   assign rsp.done_level  = out_item_ff.done_level;
   assign rsp.reschedule  = out_item_ff.reschedule;
   assign rsp.want_chars  = out_item_ff.want_chars;
   assign rsp.qualifier   = out_item_ff.qualifier;

endmodule
